// ===== rtl/pswu_pkg.sv =====
// Shared widths and codes for the pulse source waveform unit.
package pswu_pkg;

    localparam int TW = 32;
    localparam int LW = 16;
    localparam int MW = LW + 1;
    localparam int PW = MW + TW;
    localparam int AW = 5;

    typedef enum logic [2:0] {
        SEG_DELAY   = 3'd0,
        SEG_RISE    = 3'd1,
        SEG_HIGH    = 3'd2,
        SEG_FALL    = 3'd3,
        SEG_LOW     = 3'd4
    } seg_t;

    typedef enum logic [2:0] {
        REG_BASE    = 3'd0,
        REG_PULSE   = 3'd1,
        REG_DELAY   = 3'd2,
        REG_RISE    = 3'd3,
        REG_FALL    = 3'd4,
        REG_HIGH    = 3'd5,
        REG_PERIOD  = 3'd6
    } reg_idx_t;

endpackage

// ===== rtl/pswu_mod_pipe.sv =====
// Pipelined restoring reduction of the time offset modulo the period, one bit per stage.
module pswu_mod_pipe (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic                in_pre,
    input  logic [pswu_pkg::TW-1:0] in_u,
    input  logic [pswu_pkg::TW-1:0] period,
    output logic                out_valid,
    output logic                out_pre,
    output logic [pswu_pkg::TW-1:0] out_u
);
    import pswu_pkg::*;

    logic          valid_reg [TW];
    logic          pre_reg   [TW];
    logic [TW-1:0] u_reg     [TW];
    logic [TW-1:0] rem_reg   [TW];

    genvar k;
    generate
        for (k = 0; k < TW; k++)
        begin : g_stage
            logic          v_prev;
            logic          p_prev;
            logic [TW-1:0] u_prev;
            logic [TW-1:0] r_prev;
            logic [TW:0]   trial;
            logic [TW:0]   diff;
            logic [TW-1:0] r_next;

            if (k == 0)
            begin : g_first
                assign v_prev = in_valid;
                assign p_prev = in_pre;
                assign u_prev = in_u;
                assign r_prev = '0;
            end
            else
            begin : g_rest
                assign v_prev = valid_reg[k-1];
                assign p_prev = pre_reg[k-1];
                assign u_prev = u_reg[k-1];
                assign r_prev = rem_reg[k-1];
            end

            always_comb
            begin
                trial  = {r_prev, u_prev[TW-1-k]};
                diff   = trial - {1'b0, period};
                r_next = (trial >= {1'b0, period}) ? diff[TW-1:0] : trial[TW-1:0];
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[k] <= 1'b0;
                end
                else if (en)
                begin
                    valid_reg[k] <= v_prev;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    pre_reg[k] <= p_prev;
                    u_reg[k]   <= u_prev;
                    rem_reg[k] <= r_next;
                end
            end
        end
    endgenerate

    assign out_valid = valid_reg[TW-1];
    assign out_pre   = pre_reg[TW-1];
    assign out_u     = (period == '0) ? u_reg[TW-1] : rem_reg[TW-1];

endmodule

// ===== rtl/pulse_source_waveform_unit.sv =====
// Top level of the pulse source waveform unit: registers, segment selection and ramp divider.
//  Channel   | Direction | Content
//  s_axis    | in        | tdata[31:0] time_tick
//  m_axis    | out       | tdata[15:0] level, [18:16] segment, [23:19] zero
//  apb       | in/out    | seven configuration registers at 4*i
// One transaction enters per cycle while the output register is not stalled.
// A result passes the input, modulo, segment selection, product and ramp divider stages, then the output register.
// Reset clears the registers and all stage valid bits; no clearing pass is needed.
// The segment bounds are registered: end_high_reg from the registers, then end_fall_reg from end_high_reg.
// When the output register is full and not taken, every stage holds its contents.
module pulse_source_waveform_unit (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [31:0]              s_tdata,   // time_tick
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [23:0]              m_tdata,   // level, segment, zero fill
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [pswu_pkg::AW-1:0]  paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);
    import pswu_pkg::*;

    logic [LW-1:0] base_reg;
    logic [LW-1:0] pulse_reg;
    logic [TW-1:0] delay_reg;
    logic [TW-1:0] rise_reg;
    logic [TW-1:0] fall_reg;
    logic [TW-1:0] high_reg;
    logic [TW-1:0] period_reg;
    reg_idx_t      idx;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg   <= '0;
            pulse_reg  <= '0;
            delay_reg  <= '0;
            rise_reg   <= '0;
            fall_reg   <= '0;
            high_reg   <= '0;
            period_reg <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            case (idx)
                REG_BASE:   base_reg   <= pwdata[LW-1:0];
                REG_PULSE:  pulse_reg  <= pwdata[LW-1:0];
                REG_DELAY:  delay_reg  <= pwdata[TW-1:0];
                REG_RISE:   rise_reg   <= pwdata[TW-1:0];
                REG_FALL:   fall_reg   <= pwdata[TW-1:0];
                REG_HIGH:   high_reg   <= pwdata[TW-1:0];
                REG_PERIOD: period_reg <= pwdata[TW-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_BASE:   prdata = {{(32-LW){1'b0}}, base_reg};
            REG_PULSE:  prdata = {{(32-LW){1'b0}}, pulse_reg};
            REG_DELAY:  prdata = delay_reg;
            REG_RISE:   prdata = rise_reg;
            REG_FALL:   prdata = fall_reg;
            REG_HIGH:   prdata = high_reg;
            REG_PERIOD: prdata = period_reg;
            default:    prdata = '0;
        endcase
    end

    logic [TW:0]   end_high_reg;
    logic [TW+1:0] end_fall_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            end_high_reg <= '0;
            end_fall_reg <= '0;
        end
        else
        begin
            end_high_reg <= {1'b0, rise_reg} + {1'b0, high_reg};
            end_fall_reg <= {1'b0, end_high_reg} + {2'b00, fall_reg};
        end
    end

    logic en;
    logic out_valid_reg;
    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    // Input stage.
    logic          a_valid_reg;
    logic          a_pre_reg;
    logic [TW-1:0] a_u_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_pre_reg <= (s_tdata[TW-1:0] <= delay_reg);
            a_u_reg   <= s_tdata[TW-1:0] - delay_reg;
        end
    end

    logic          m_valid;
    logic          m_pre;
    logic [TW-1:0] m_u;

    pswu_mod_pipe u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (a_valid_reg),
        .in_pre    (a_pre_reg),
        .in_u      (a_u_reg),
        .period    (period_reg),
        .out_valid (m_valid),
        .out_pre   (m_pre),
        .out_u     (m_u)
    );

    // Segment selection stage.
    logic signed [MW-1:0] diff_lvl;
    logic [MW-1:0]        mag;
    logic [TW:0]          fall_off;
    seg_t                 b_seg_next;
    logic [TW-1:0]        b_num_next;
    logic [TW-1:0]        b_den_next;
    logic [LW-1:0]        b_from_next;
    logic                 b_neg_next;
    logic [MW-1:0]        b_mag_next;

    always_comb
    begin
        diff_lvl = MW'($signed(pulse_reg)) - MW'($signed(base_reg));
        mag      = diff_lvl[MW-1] ? MW'(-diff_lvl) : diff_lvl;
        fall_off = {1'b0, m_u} - end_high_reg;
        b_seg_next  = SEG_LOW;
        b_num_next  = '0;
        b_den_next  = TW'(1);
        b_from_next = base_reg;
        b_neg_next  = 1'b0;
        b_mag_next  = '0;
        if (m_pre)
        begin
            b_seg_next = SEG_DELAY;
        end
        else if ((rise_reg != '0) && (m_u <= rise_reg))
        begin
            b_seg_next = SEG_RISE;
            b_num_next = m_u;
            b_den_next = rise_reg;
            b_neg_next = diff_lvl[MW-1];
            b_mag_next = mag;
        end
        else if ({1'b0, m_u} <= end_high_reg)
        begin
            b_seg_next  = SEG_HIGH;
            b_from_next = pulse_reg;
        end
        else if ((fall_reg != '0) && ({2'b00, m_u} <= end_fall_reg))
        begin
            b_seg_next  = SEG_FALL;
            b_num_next  = fall_off[TW-1:0];
            b_den_next  = fall_reg;
            b_from_next = pulse_reg;
            b_neg_next  = !diff_lvl[MW-1] && (diff_lvl != '0);
            b_mag_next  = mag;
        end
    end

    logic          b_valid_reg;
    seg_t          b_seg_reg;
    logic [TW-1:0] b_num_reg;
    logic [TW-1:0] b_den_reg;
    logic [LW-1:0] b_from_reg;
    logic          b_neg_reg;
    logic [MW-1:0] b_mag_reg;

    // Product stage.
    logic          c_valid_reg;
    seg_t          c_seg_reg;
    logic [PW-1:0] c_prod_reg;
    logic [TW-1:0] c_den_reg;
    logic [LW-1:0] c_from_reg;
    logic          c_neg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            b_valid_reg <= m_valid;
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_seg_reg  <= b_seg_next;
            b_num_reg  <= b_num_next;
            b_den_reg  <= b_den_next;
            b_from_reg <= b_from_next;
            b_neg_reg  <= b_neg_next;
            b_mag_reg  <= b_mag_next;
            c_seg_reg  <= b_seg_reg;
            c_prod_reg <= PW'(b_mag_reg) * PW'(b_num_reg);
            c_den_reg  <= b_den_reg;
            c_from_reg <= b_from_reg;
            c_neg_reg  <= b_neg_reg;
        end
    end

    // Ramp divider: the quotient is below 2**MW, so the top bits start as the remainder.
    logic          d_valid_reg [MW];
    seg_t          d_seg_reg   [MW];
    logic [TW-1:0] d_rem_reg   [MW];
    logic [MW-1:0] d_low_reg   [MW];
    logic [MW-1:0] d_q_reg     [MW];
    logic [TW-1:0] d_den_reg   [MW];
    logic [LW-1:0] d_from_reg  [MW];
    logic          d_neg_reg   [MW];

    genvar k;
    generate
        for (k = 0; k < MW; k++)
        begin : g_div
            logic          v_prev;
            seg_t          s_prev;
            logic [TW-1:0] r_prev;
            logic [MW-1:0] l_prev;
            logic [MW-1:0] q_prev;
            logic [TW-1:0] dn_prev;
            logic [LW-1:0] f_prev;
            logic          n_prev;
            logic [TW:0]   trial;
            logic [TW:0]   diff;
            logic          take;

            if (k == 0)
            begin : g_first
                assign v_prev  = c_valid_reg;
                assign s_prev  = c_seg_reg;
                assign r_prev  = c_prod_reg[PW-1:MW];
                assign l_prev  = c_prod_reg[MW-1:0];
                assign q_prev  = '0;
                assign dn_prev = c_den_reg;
                assign f_prev  = c_from_reg;
                assign n_prev  = c_neg_reg;
            end
            else
            begin : g_rest
                assign v_prev  = d_valid_reg[k-1];
                assign s_prev  = d_seg_reg[k-1];
                assign r_prev  = d_rem_reg[k-1];
                assign l_prev  = d_low_reg[k-1];
                assign q_prev  = d_q_reg[k-1];
                assign dn_prev = d_den_reg[k-1];
                assign f_prev  = d_from_reg[k-1];
                assign n_prev  = d_neg_reg[k-1];
            end

            always_comb
            begin
                trial = {r_prev, l_prev[MW-1]};
                diff  = trial - {1'b0, dn_prev};
                take  = (trial >= {1'b0, dn_prev});
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    d_valid_reg[k] <= 1'b0;
                end
                else if (en)
                begin
                    d_valid_reg[k] <= v_prev;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    d_seg_reg[k]  <= s_prev;
                    d_rem_reg[k]  <= take ? diff[TW-1:0] : trial[TW-1:0];
                    d_low_reg[k]  <= {l_prev[MW-2:0], 1'b0};
                    d_q_reg[k]    <= {q_prev[MW-2:0], take};
                    d_den_reg[k]  <= dn_prev;
                    d_from_reg[k] <= f_prev;
                    d_neg_reg[k]  <= n_prev;
                end
            end
        end
    endgenerate

    // Output register.
    logic [LW-1:0] q_low;
    logic [LW-1:0] level_next;
    logic [LW-1:0] out_level_reg;
    seg_t          out_seg_reg;

    assign q_low      = d_q_reg[MW-1][LW-1:0];
    assign level_next = d_neg_reg[MW-1] ? (d_from_reg[MW-1] - q_low)
                                        : (d_from_reg[MW-1] + q_low);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= d_valid_reg[MW-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_level_reg <= level_next;
            out_seg_reg   <= d_seg_reg[MW-1];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(24-LW-3){1'b0}}, out_seg_reg, out_level_reg};

endmodule

// ===== rtl/pswu_checker.sv =====
// Port-level checks for the pulse source waveform unit, bound to the top level.
module pswu_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        pready
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output transaction dropped or changed while stalled");

    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input accepted while the pipeline is stalled");

    a_seg: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[18:16] <= 3'd4) && (m_tdata[23:19] == 5'd0))
        else $error("bad segment code or padding");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("configuration port not ready");

endmodule

bind pulse_source_waveform_unit pswu_checker u_pswu_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .pready   (pready)
);
